// File: rtl/core/hclp_pkg.sv
// Shared types and constants for the hex capture line parser.
// Holds the result record, the parser-to-queue transfer bundle and the code values.
package hclp_pkg;

    localparam int unsigned DEF_MAX_FRAME_BYTES = 65536;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int unsigned LEN_W   = 17;
    localparam int unsigned BYTES_W = 48;

    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_KEYWORD  = 3'd1;
    localparam logic [2:0] ERR_HEX      = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_EMPTY    = 3'd4;

    localparam logic [1:0] STAT_VALID   = 2'd0;
    localparam logic [1:0] STAT_ERROR   = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic               dir_in;
        logic [LEN_W-1:0]   len;
        logic [31:0]        hash;
        logic [2:0]         err;
        logic [31:0]        line;
        logic [31:0]        frames;
        logic [31:0]        in_frames;
        logic [31:0]        out_frames;
        logic [BYTES_W-1:0] bytes;
        logic [1:0]         status;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// File: rtl/core/hex_capture_line_parser_fnv1a.sv
// Top level of the hex capture line parser with FNV-1a frame hashing.
// Depends on hclp_pkg, hclp_parse and hclp_rq.
//
// Input channel (i_valid / o_ready): one text character per transaction, or an
// end-of-capture marker when i_end_of_capture is high. Output channel
// (o_valid / i_ready): one result record per transaction; a character gives at
// most one result, an end-of-capture gives an optional frame or error result
// followed by a summary, with o_last_of_run marking the final one.
// A result passes through the input register, then the parser stage writing
// the result queue, before it is shown.
// Throughput: one character per cycle while the receiver keeps up; the parser
// stage runs whenever the four-entry result queue has room for two records.
// Reset clears the parser state, totals, the input register and the queue.
// When the receiver stalls, results collect in the queue; once it holds more
// than two, the parser stage holds and o_ready drops after the input register
// fills. After a line error characters are dropped until reset.
module hex_capture_line_parser_fnv1a #(
    parameter int unsigned MAX_FRAME_BYTES = hclp_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_text_char,
    input  logic                           i_end_of_capture,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_result_kind,
    output logic                           o_direction_in,
    output logic [hclp_pkg::LEN_W-1:0]     o_frame_length,
    output logic [31:0]                    o_frame_hash,
    output logic [2:0]                     o_error_code,
    output logic [31:0]                    o_line_number,
    output logic [31:0]                    o_frame_count,
    output logic [31:0]                    o_in_frame_total,
    output logic [31:0]                    o_out_frame_total,
    output logic [hclp_pkg::BYTES_W-1:0]   o_byte_total,
    output logic [1:0]                     o_capture_status,
    output logic                           o_last_of_run
);
    import hclp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eoc;
    logic       fire;
    logic       room;
    t_push      push;
    t_result    head;

    assign fire    = r_in_valid && room;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_text_char;
            r_eoc  <= i_end_of_capture;
        end
    end

    hclp_parse #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (fire),
        .i_char (r_char),
        .i_eoc  (r_eoc),
        .o_push (push)
    );

    hclp_rq u_rq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (i_ready),
        .o_head (head),
        .o_valid(o_valid),
        .o_room (room)
    );

    assign o_result_kind     = head.kind;
    assign o_direction_in    = head.dir_in;
    assign o_frame_length    = head.len;
    assign o_frame_hash      = head.hash;
    assign o_error_code      = head.err;
    assign o_line_number     = head.line;
    assign o_frame_count     = head.frames;
    assign o_in_frame_total  = head.in_frames;
    assign o_out_frame_total = head.out_frames;
    assign o_byte_total      = head.bytes;
    assign o_capture_status  = head.status;
    assign o_last_of_run     = head.last;

endmodule

// File: rtl/core/hclp_parse.sv
// Per-character parser state, FNV-1a hashing and capture totals.
// Depends on hclp_pkg; produces up to two result records per transaction.
module hclp_parse #(
    parameter int unsigned MAX_FRAME_BYTES = hclp_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_char,
    input  logic            i_eoc,
    output hclp_pkg::t_push o_push
);
    import hclp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_T     = 8'h54;

    typedef enum logic [2:0] {
        PH_START, PH_LEAD, PH_KW_IN, PH_KW_OUT, PH_HI, PH_LO, PH_SKIP
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_kp, n_kp;
    logic               r_dir, n_dir;
    logic [3:0]         r_hn, n_hn;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [31:0]        r_hash, n_hash;
    logic [31:0]        r_line, n_line;
    logic [31:0]        r_frames, n_frames;
    logic [31:0]        r_in, n_in;
    logic [31:0]        r_out, n_out;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic               r_halted, n_halted;

    logic                 is_ws, is_stop, is_nl, is_hex;
    logic [3:0]           hval;
    logic                 kw_in_ok, kw_out_ok;
    logic [31:0]          hash_x;
    logic [BYTES_W:0]     bytes_sum;
    logic [CNT_W+LEN_W-1:0] cnt_ext;
    logic                 raise, report, summ;
    logic [2:0]           err_code;
    logic [1:0]           status;
    t_result              res_e, res_s;

    always_comb begin
        is_ws   = (i_char == CH_SPACE) || (i_char == CH_TAB);
        is_stop = (i_char == CH_HASH) || (i_char == CH_NUL);
        is_nl   = (i_char == CH_NL);
        is_hex  = 1'b1;
        hval    = i_char[3:0];
        if (i_char inside {[8'h30:8'h39]}) begin
            hval = i_char[3:0];
        end else if (i_char inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            hval = i_char[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        case (r_kp)
            2'd0:    kw_in_ok = (i_char == CH_I);
            2'd1:    kw_in_ok = (i_char == CH_N);
            2'd2:    kw_in_ok = (i_char == CH_SPACE);
            default: kw_in_ok = 1'b0;
        endcase
        case (r_kp)
            2'd0:    kw_out_ok = (i_char == CH_O);
            2'd1:    kw_out_ok = (i_char == CH_U);
            2'd2:    kw_out_ok = (i_char == CH_T);
            default: kw_out_ok = (i_char == CH_SPACE);
        endcase
    end

    assign hash_x    = r_hash ^ {24'd0, r_hn, hval};
    assign bytes_sum = {1'b0, r_bytes} + (BYTES_W + 1)'(r_cnt);
    assign cnt_ext   = {{LEN_W{1'b0}}, r_cnt};

    always_comb begin
        n_phase  = r_phase;
        n_kp     = r_kp;
        n_dir    = r_dir;
        n_hn     = r_hn;
        n_cnt    = r_cnt;
        n_hash   = r_hash;
        n_line   = r_line;
        n_frames = r_frames;
        n_in     = r_in;
        n_out    = r_out;
        n_bytes  = r_bytes;
        n_halted = r_halted;
        raise    = 1'b0;
        report   = 1'b0;
        summ     = 1'b0;
        err_code = ERR_NONE;

        if (i_fire) begin
            if (i_eoc) begin
                summ = 1'b1;
                if (!r_halted) begin
                    case (r_phase)
                        PH_START: begin
                            n_phase = PH_START;
                        end
                        PH_KW_IN, PH_KW_OUT: begin
                            raise    = 1'b1;
                            err_code = ERR_KEYWORD;
                        end
                        PH_LO: begin
                            raise    = 1'b1;
                            err_code = ERR_HEX;
                        end
                        PH_HI: begin
                            if (r_cnt == '0) begin
                                raise    = 1'b1;
                                err_code = ERR_EMPTY;
                            end else begin
                                report = 1'b1;
                                n_line = r_line + 32'd1;
                            end
                        end
                        default: begin
                            n_line = r_line + 32'd1;
                        end
                    endcase
                    if (!raise) begin
                        n_phase = PH_START;
                        n_kp    = 2'd0;
                    end
                end
            end else if (!r_halted) begin
                case (r_phase)
                    PH_START, PH_LEAD: begin
                        if (is_ws) begin
                            n_phase = PH_LEAD;
                        end else if (is_nl) begin
                            n_line  = r_line + 32'd1;
                            n_phase = PH_START;
                        end else if (is_stop) begin
                            n_phase = PH_SKIP;
                        end else if (i_char == CH_I) begin
                            n_phase = PH_KW_IN;
                            n_kp    = 2'd1;
                        end else if (i_char == CH_O) begin
                            n_phase = PH_KW_OUT;
                            n_kp    = 2'd1;
                        end else begin
                            raise    = 1'b1;
                            err_code = ERR_KEYWORD;
                        end
                    end
                    PH_KW_IN: begin
                        if (kw_in_ok) begin
                            if (r_kp == 2'd2) begin
                                n_dir   = 1'b1;
                                n_cnt   = '0;
                                n_hash  = FNV_BASIS;
                                n_kp    = 2'd0;
                                n_phase = PH_HI;
                            end else begin
                                n_kp = r_kp + 2'd1;
                            end
                        end else begin
                            raise    = 1'b1;
                            err_code = ERR_KEYWORD;
                        end
                    end
                    PH_KW_OUT: begin
                        if (kw_out_ok) begin
                            if (r_kp == 2'd3) begin
                                n_dir   = 1'b0;
                                n_cnt   = '0;
                                n_hash  = FNV_BASIS;
                                n_kp    = 2'd0;
                                n_phase = PH_HI;
                            end else begin
                                n_kp = r_kp + 2'd1;
                            end
                        end else begin
                            raise    = 1'b1;
                            err_code = ERR_KEYWORD;
                        end
                    end
                    PH_HI: begin
                        if (is_ws) begin
                            n_phase = PH_HI;
                        end else if (is_nl || is_stop) begin
                            if (r_cnt == '0) begin
                                raise    = 1'b1;
                                err_code = ERR_EMPTY;
                            end else begin
                                report = 1'b1;
                                if (is_nl) begin
                                    n_line  = r_line + 32'd1;
                                    n_phase = PH_START;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end else if (!is_hex) begin
                            raise    = 1'b1;
                            err_code = ERR_HEX;
                        end else begin
                            n_hn    = hval;
                            n_phase = PH_LO;
                        end
                    end
                    PH_LO: begin
                        if (!is_hex) begin
                            raise    = 1'b1;
                            err_code = ERR_HEX;
                        end else if (r_cnt >= CNT_W'(MAX_FRAME_BYTES)) begin
                            raise    = 1'b1;
                            err_code = ERR_OVERFLOW;
                        end else begin
                            n_hash  = 32'(hash_x * FNV_PRIME);
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_phase = PH_HI;
                        end
                    end
                    default: begin
                        if (is_nl) begin
                            n_line  = r_line + 32'd1;
                            n_phase = PH_START;
                        end
                    end
                endcase
            end
        end

        if (raise) begin
            n_halted = 1'b1;
        end
        if (report) begin
            n_frames = r_frames + 32'd1;
            if (r_dir) begin
                n_in = r_in + 32'd1;
            end else begin
                n_out = r_out + 32'd1;
            end
            n_bytes = bytes_sum[BYTES_W] ? {BYTES_W{1'b1}} : bytes_sum[BYTES_W-1:0];
        end

        if (n_halted) begin
            status = STAT_ERROR;
        end else if (n_frames == 32'd0 || n_in == 32'd0 || n_out == 32'd0) begin
            status = STAT_MISSING;
        end else begin
            status = STAT_VALID;
        end
    end

    always_comb begin
        res_e.kind       = report ? KIND_FRAME : KIND_ERROR;
        res_e.dir_in     = report ? r_dir : 1'b0;
        res_e.len        = report ? cnt_ext[LEN_W-1:0] : '0;
        res_e.hash       = report ? r_hash : 32'd0;
        res_e.err        = err_code;
        res_e.line       = r_line + 32'd1;
        res_e.frames     = n_frames;
        res_e.in_frames  = n_in;
        res_e.out_frames = n_out;
        res_e.bytes      = n_bytes;
        res_e.status     = STAT_VALID;
        res_e.last       = !summ;

        res_s.kind       = KIND_SUMMARY;
        res_s.dir_in     = 1'b0;
        res_s.len        = '0;
        res_s.hash       = 32'd0;
        res_s.err        = ERR_NONE;
        res_s.line       = n_line;
        res_s.frames     = n_frames;
        res_s.in_frames  = n_in;
        res_s.out_frames = n_out;
        res_s.bytes      = n_bytes;
        res_s.status     = status;
        res_s.last       = 1'b1;

        o_push.r0  = (raise || report) ? res_e : res_s;
        o_push.r1  = res_s;
        o_push.cnt = 2'(raise || report) + 2'(summ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_kp     <= 2'd0;
            r_dir    <= 1'b0;
            r_hn     <= 4'd0;
            r_cnt    <= '0;
            r_hash   <= FNV_BASIS;
            r_line   <= 32'd0;
            r_frames <= 32'd0;
            r_in     <= 32'd0;
            r_out    <= 32'd0;
            r_bytes  <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_kp     <= n_kp;
            r_dir    <= n_dir;
            r_hn     <= n_hn;
            r_cnt    <= n_cnt;
            r_hash   <= n_hash;
            r_line   <= n_line;
            r_frames <= n_frames;
            r_in     <= n_in;
            r_out    <= n_out;
            r_bytes  <= n_bytes;
            r_halted <= n_halted;
        end
    end

endmodule

// File: rtl/core/hclp_rq.sv
// Result queue: takes up to two result records per cycle, hands out one.
// Depends on hclp_pkg for the record type and depth.
module hclp_rq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hclp_pkg::t_push   i_push,
    input  logic              i_pop,
    output hclp_pkg::t_result o_head,
    output logic              o_valid,
    output logic              o_room
);
    import hclp_pkg::*;

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp, r_rp;
    logic [RQ_AW:0]   r_count, n_count;
    logic [RQ_AW-1:0] wp1;
    logic             pop_ok;

    assign pop_ok  = i_pop && (r_count != '0);
    assign wp1     = r_wp + RQ_AW'(1);
    assign n_count = r_count + (RQ_AW + 1)'(i_push.cnt) - (RQ_AW + 1)'(pop_ok);

    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= (RQ_AW + 1)'(RQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + RQ_AW'(i_push.cnt);
            r_rp    <= r_rp + RQ_AW'(pop_ok);
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/hclp_chk.sv
// Port-level checks for the hex capture line parser, bound to the top level.
// Depends on hclp_pkg for the result codes.
module hclp_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [1:0]                   o_result_kind,
    input logic [hclp_pkg::LEN_W-1:0]   o_frame_length,
    input logic [31:0]                  o_frame_hash,
    input logic [2:0]                   o_error_code,
    input logic [1:0]                   o_capture_status,
    input logic                         o_last_of_run
);
    import hclp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_kind)
            && $stable(o_frame_hash) && $stable(o_last_of_run))
        else $error("result changed while stalled");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_ERROR |->
            o_error_code != ERR_NONE && o_frame_length == '0 && o_frame_hash == 32'd0)
        else $error("error result with bad fields");

    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_FRAME |->
            o_error_code == ERR_NONE && o_frame_length != '0
            && o_capture_status == STAT_VALID)
        else $error("frame report with bad fields");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> o_result_kind != KIND_SUMMARY)
        else $error("summary not marked last");

endmodule

bind hex_capture_line_parser_fnv1a hclp_chk u_hclp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_result_kind   (o_result_kind),
    .o_frame_length  (o_frame_length),
    .o_frame_hash    (o_frame_hash),
    .o_error_code    (o_error_code),
    .o_capture_status(o_capture_status),
    .o_last_of_run   (o_last_of_run)
);

// File: sim/tb.sv
// Self-checking testbench for hex_capture_line_parser_fnv1a: streams capture text
// and end markers, predicts frame, error and summary records, and checks each one.
// Depends on hclp_pkg and the RTL top level only.
import hclp_pkg::*;

typedef enum logic [2:0] {
    LN_START, LN_LEAD, LN_KW_IN, LN_KW_OUT, LN_HI, LN_LO, LN_SKIP
} line_phase_e;

localparam logic [7:0] CH_NUL   = 8'h00;
localparam logic [7:0] CH_TAB   = 8'h09;
localparam logic [7:0] CH_NL    = 8'h0A;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_HASH  = 8'h23;

class capture_scoreboard;
    line_phase_e        phase;
    int unsigned        kw_pos;
    int unsigned        n_bytes;
    logic               dir_in;
    logic [3:0]         hi_nib;
    logic [31:0]        hash;
    logic [31:0]        lines;
    logic [31:0]        frames;
    logic [31:0]        in_frames;
    logic [31:0]        out_frames;
    logic [BYTES_W-1:0] bytes;
    bit                 halted;
    string              kw_in;
    string              kw_out;
    t_result            expected_q[$];
    int unsigned        n_fail;
    int unsigned        n_checked;
    int unsigned        n_frame_rpt;
    int unsigned        n_error_rpt;
    int unsigned        n_summary_rpt;
    int unsigned        longest;

    function new();
        phase = LN_START;
        kw_pos = 0;
        n_bytes = 0;
        dir_in = 1'b0;
        hi_nib = '0;
        hash = FNV_BASIS;
        lines = '0;
        frames = '0;
        in_frames = '0;
        out_frames = '0;
        bytes = '0;
        halted = 1'b0;
        kw_in = "IN ";
        kw_out = "OUT ";
        n_fail = 0;
        n_checked = 0;
        n_frame_rpt = 0;
        n_error_rpt = 0;
        n_summary_rpt = 0;
        longest = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void queue_result(logic [1:0] kind, logic dir, int unsigned len, logic [31:0] h,
                               logic [2:0] err, logic [31:0] line, logic [1:0] status);
        t_result r;
        r.kind = kind;
        r.dir_in = dir;
        r.len = LEN_W'(len);
        r.hash = h;
        r.err = err;
        r.line = line;
        r.frames = frames;
        r.in_frames = in_frames;
        r.out_frames = out_frames;
        r.bytes = bytes;
        r.status = status;
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    function void flag_error(logic [2:0] code);
        halted = 1'b1;
        queue_result(KIND_ERROR, 1'b0, 0, '0, code, lines + 1, '0);
    endfunction

    function void close_frame();
        logic [BYTES_W:0] sum;
        if (n_bytes == 0) begin
            flag_error(ERR_EMPTY);
            return;
        end
        frames++;
        if (dir_in) in_frames++;
        else out_frames++;
        sum = bytes + n_bytes;
        bytes = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
        if (n_bytes > longest) longest = n_bytes;
        queue_result(KIND_FRAME, dir_in, n_bytes, hash, ERR_NONE, lines + 1, '0);
    endfunction

    function void open_frame(logic dir);
        dir_in = dir;
        n_bytes = 0;
        hash = FNV_BASIS;
        kw_pos = 0;
        phase = LN_HI;
    endfunction

    function int hex_val(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function void parse_char(logic [7:0] c);
        bit ws;
        bit stop;
        int d;
        ws = (c == CH_SPACE) || (c == CH_TAB);
        stop = (c == CH_HASH) || (c == CH_NUL);
        case (phase)
            LN_START, LN_LEAD: begin
                if (ws) phase = LN_LEAD;
                else if (c == CH_NL) begin
                    lines++;
                    phase = LN_START;
                end else if (stop) phase = LN_SKIP;
                else if (c == "I") begin
                    phase = LN_KW_IN;
                    kw_pos = 1;
                end else if (c == "O") begin
                    phase = LN_KW_OUT;
                    kw_pos = 1;
                end else flag_error(ERR_KEYWORD);
            end
            LN_KW_IN: begin
                if (kw_pos < 3 && c == kw_in[kw_pos]) begin
                    kw_pos++;
                    if (kw_pos == 3) open_frame(1'b1);
                end else flag_error(ERR_KEYWORD);
            end
            LN_KW_OUT: begin
                if (kw_pos < 4 && c == kw_out[kw_pos]) begin
                    if (kw_pos == 3) open_frame(1'b0);
                    else kw_pos++;
                end else flag_error(ERR_KEYWORD);
            end
            LN_HI: begin
                if (c == CH_NL || stop) begin
                    close_frame();
                    if (!halted) begin
                        if (c == CH_NL) begin
                            lines++;
                            phase = LN_START;
                        end else phase = LN_SKIP;
                    end
                end else if (!ws) begin
                    d = hex_val(c);
                    if (d < 0) flag_error(ERR_HEX);
                    else begin
                        hi_nib = d[3:0];
                        phase = LN_LO;
                    end
                end
            end
            LN_LO: begin
                d = hex_val(c);
                if (d < 0) flag_error(ERR_HEX);
                else if (n_bytes >= DEF_MAX_FRAME_BYTES) flag_error(ERR_OVERFLOW);
                else begin
                    hash = hash ^ {24'd0, hi_nib, d[3:0]};
                    hash = hash * FNV_PRIME;
                    n_bytes++;
                    phase = LN_HI;
                end
            end
            default: begin
                if (c == CH_NL) begin
                    lines++;
                    phase = LN_START;
                end
            end
        endcase
    endfunction

    function void end_capture();
        logic [1:0] status;
        if (!halted) begin
            case (phase)
                LN_START: ;
                LN_KW_IN, LN_KW_OUT: flag_error(ERR_KEYWORD);
                LN_LO: flag_error(ERR_HEX);
                LN_HI: begin
                    close_frame();
                    if (!halted) lines++;
                end
                default: lines++;
            endcase
            if (!halted) begin
                phase = LN_START;
                kw_pos = 0;
            end
        end
        if (halted) status = STAT_ERROR;
        else if (frames == 0 || in_frames == 0 || out_frames == 0) status = STAT_MISSING;
        else status = STAT_VALID;
        queue_result(KIND_SUMMARY, 1'b0, 0, '0, ERR_NONE, lines, status);
    endfunction

    // Returns 1 when the transaction was not dropped by a halted parser.
    function bit note_input(logic [7:0] c, bit eoc);
        int unsigned before_n;
        bit taken;
        t_result r;
        before_n = expected_q.size();
        taken = eoc || !halted;
        if (eoc) end_capture();
        else if (!halted) parse_char(c);
        if (expected_q.size() > before_n) begin
            r = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
        end
        return taken;
    endfunction

    function bit field_off(string name, logic [63:0] want, logic [63:0] got);
        if (want === got) return 1'b0;
        if (n_fail < 10)
            $display("result %0d: %s expected 0x%0h, got 0x%0h", n_checked, name, want, got);
        return 1'b1;
    endfunction

    function void check_result(t_result got);
        t_result want;
        bit bad;
        n_checked++;
        if (got.kind == KIND_FRAME) n_frame_rpt++;
        else if (got.kind == KIND_ERROR) n_error_rpt++;
        else n_summary_rpt++;
        if (expected_q.size() == 0) begin
            if (n_fail < 10)
                $display("result %0d: unexpected record, kind %0d", n_checked, got.kind);
            n_fail++;
            return;
        end
        want = expected_q.pop_front();
        bad = field_off("kind", want.kind, got.kind)
            | field_off("direction", want.dir_in, got.dir_in)
            | field_off("length", want.len, got.len)
            | field_off("hash", want.hash, got.hash)
            | field_off("error", want.err, got.err)
            | field_off("line", want.line, got.line)
            | field_off("frames", want.frames, got.frames)
            | field_off("in frames", want.in_frames, got.in_frames)
            | field_off("out frames", want.out_frames, got.out_frames)
            | field_off("bytes", want.bytes, got.bytes)
            | field_off("status", want.status, got.status)
            | field_off("last", want.last, got.last);
        if (bad) n_fail++;
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT      = 2_000_000;
    localparam int unsigned ITEMS      = 1450;
    localparam int unsigned LONG_HOLD  = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [7:0]           i_text_char = '0;
    logic                 i_end_of_capture = 1'b0;
    logic                 i_ready = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [1:0]           o_result_kind;
    logic                 o_direction_in;
    logic [LEN_W-1:0]     o_frame_length;
    logic [31:0]          o_frame_hash;
    logic [2:0]           o_error_code;
    logic [31:0]          o_line_number;
    logic [31:0]          o_frame_count;
    logic [31:0]          o_in_frame_total;
    logic [31:0]          o_out_frame_total;
    logic [BYTES_W-1:0]   o_byte_total;
    logic [1:0]           o_capture_status;
    logic                 o_last_of_run;

    capture_scoreboard sb;
    int unsigned       n_cycles = 0;
    int unsigned       n_items = 0;
    bit                idle_on = 1'b1;
    bit                hold_req = 1'b0;
    int unsigned       closing_case = 0;

    hex_capture_line_parser_fnv1a u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_text_char       (i_text_char),
        .i_end_of_capture  (i_end_of_capture),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_result_kind     (o_result_kind),
        .o_direction_in    (o_direction_in),
        .o_frame_length    (o_frame_length),
        .o_frame_hash      (o_frame_hash),
        .o_error_code      (o_error_code),
        .o_line_number     (o_line_number),
        .o_frame_count     (o_frame_count),
        .o_in_frame_total  (o_in_frame_total),
        .o_out_frame_total (o_out_frame_total),
        .o_byte_total      (o_byte_total),
        .o_capture_status  (o_capture_status),
        .o_last_of_run     (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
    end

    task automatic put_item(logic [7:0] c, bit eoc);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_text_char <= c;
        i_end_of_capture <= eoc;
        do @(posedge i_clk); while (!o_ready);
        if (sb.note_input(c, eoc)) n_items++;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
    endtask

    task automatic put_eoc();
        put_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 10) return 8'("0" + v);
        if ($urandom_range(0, 1)) return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    task automatic put_ws(int unsigned n);
        repeat (n) put_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    endtask

    task automatic put_junk(int unsigned n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
            put_item(c, 1'b0);
        end
    endtask

    task automatic put_frame(bit dir, int unsigned n);
        logic [7:0] b;
        if (dir) put_text("IN ");
        else put_text("OUT ");
        if ($urandom_range(0, 3) == 0) put_ws($urandom_range(1, 3));
        for (int unsigned i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 3) != 0) put_ws($urandom_range(1, 2));
            b = 8'($urandom_range(0, 255));
            put_item(hex_char(b[7:4]), 1'b0);
            put_item(hex_char(b[3:0]), 1'b0);
        end
    endtask

    task automatic put_line_end();
        case ($urandom_range(0, 5))
            3: begin
                put_ws($urandom_range(1, 3));
                put_item(CH_NL, 1'b0);
            end
            4: begin
                put_item(CH_HASH, 1'b0);
                put_junk($urandom_range(0, 6));
                put_item(CH_NL, 1'b0);
            end
            5: begin
                put_item(CH_NUL, 1'b0);
                put_junk($urandom_range(0, 6));
                put_item(CH_NL, 1'b0);
            end
            default: put_item(CH_NL, 1'b0);
        endcase
    endtask

    function automatic int unsigned frame_size();
        if ($urandom_range(0, 9) == 0) return $urandom_range(9, 40);
        return $urandom_range(1, 8);
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic random_line();
        case ($urandom_range(0, 19))
            0, 1: begin
                if ($urandom_range(0, 1)) put_ws($urandom_range(1, 3));
                put_item(CH_NL, 1'b0);
            end
            2, 3: begin
                if ($urandom_range(0, 1)) put_ws($urandom_range(1, 3));
                put_item($urandom_range(0, 1) ? CH_HASH : CH_NUL, 1'b0);
                put_junk($urandom_range(0, 8));
                put_item(CH_NL, 1'b0);
            end
            4: begin
                case ($urandom_range(0, 3))
                    1: put_ws($urandom_range(1, 3));
                    2: begin
                        put_item(CH_HASH, 1'b0);
                        put_junk($urandom_range(0, 4));
                    end
                    3: begin
                        put_frame(1'($urandom_range(0, 1)), frame_size());
                        if ($urandom_range(0, 1)) put_ws($urandom_range(1, 2));
                    end
                    default: ;
                endcase
                put_eoc();
            end
            default: begin
                put_frame(1'($urandom_range(0, 1)), frame_size());
                put_line_end();
            end
        endcase
    endtask

    task automatic put_closing_error();
        logic [7:0] c;
        closing_case = $urandom_range(0, 9);
        case (closing_case)
            0: begin
                do c = 8'($urandom_range(0, 255));
                while (c inside {CH_SPACE, CH_TAB, CH_NL, CH_HASH, CH_NUL, "I", "O"});
                put_item(c, 1'b0);
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: put_text("IN\t");
                    1: put_text("In ");
                    2: put_text("OUT\t");
                    default: put_text("OuT ");
                endcase
            end
            2: put_text("OU\n");
            3: begin
                put_text("OUT");
                put_eoc();
            end
            4: begin
                put_text("IN 01 ");
                c = $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                         : 8'("g" + $urandom_range(0, 19));
                put_item(c, 1'b0);
            end
            5: begin
                put_text("OUT 1");
                case ($urandom_range(0, 3))
                    0: put_item(CH_SPACE, 1'b0);
                    1: put_item(CH_HASH, 1'b0);
                    2: put_item(CH_NUL, 1'b0);
                    default: put_item(CH_NL, 1'b0);
                endcase
            end
            6: begin
                put_text("IN 1");
                put_eoc();
            end
            7: begin
                put_text("OUT ");
                put_ws($urandom_range(0, 2));
                case ($urandom_range(0, 2))
                    0: put_item(CH_HASH, 1'b0);
                    1: put_item(CH_NUL, 1'b0);
                    default: put_item(CH_NL, 1'b0);
                endcase
            end
            8: begin
                put_text("IN ");
                put_eoc();
            end
            default: put_text("OUT 12 3\t");
        endcase
    endtask

    // result side: check at each accepted transaction, then pick next ready
    initial begin
        t_result     got;
        int unsigned stall;
        stall = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                got = {o_result_kind, o_direction_in, o_frame_length, o_frame_hash,
                       o_error_code, o_line_number, o_frame_count, o_in_frame_total,
                       o_out_frame_total, o_byte_total, o_capture_status, o_last_of_run};
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
            end
        end
    end

    initial begin
        while (n_cycles < LIMIT) @(posedge i_clk);
        $display("timed out after %0d cycles, %0d results outstanding", n_cycles, sb.pending());
        $display("FAILURE");
        $finish;
    end

    initial begin
        bit          hold_done;
        bit          drain_done;
        int unsigned next_seg;
        sb = new();
        hold_done = 1'b0;
        drain_done = 1'b0;
        next_seg = 150;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put_eoc();
        put_text("IN 00fF\n");
        put_text("OUT 9A #\n");
        put_eoc();
        put_item(CH_TAB, 1'b0);
        put_eoc();

        while (n_items < ITEMS) begin
            if (n_items >= next_seg) begin
                idle_on = ($urandom_range(0, 3) != 0);
                next_seg += 150;
            end
            if (!hold_done && n_items >= 400) begin
                hold_done = 1'b1;
                hold_req = 1'b1;
            end
            if (!drain_done && n_items >= 900) begin
                drain_done = 1'b1;
                drain();
            end
            random_line();
        end

        // hold steady for the long frame and the halting error
        idle_on = 1'b0;
        put_frame(1'($urandom_range(0, 1)), $urandom_range(41, 48));
        put_item(CH_NL, 1'b0);
        put_eoc();
        put_closing_error();
        put_junk($urandom_range(1, 4));
        put_eoc();
        put_junk(1);
        put_eoc();
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d transactions sent, %0d records checked: %0d frames, %0d errors, %0d summaries",
                 n_items, sb.n_checked, sb.n_frame_rpt, sb.n_error_rpt, sb.n_summary_rpt);
        $display("longest frame %0d bytes, closing error case %0d, %0d mismatching records",
                 sb.longest, closing_case, sb.n_fail);
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
